### rtl/bs3_pkg.sv
// Shared types, codes and constant tables for the 3x3 box smoothing block.
`default_nettype none
package bs3_pkg;
  localparam int DATA_W      = 48;        // three 16-bit channels on the stream
  localparam int FIELD_W     = 16;
  localparam int SIZE_W      = 11;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 25;
  localparam int COUNT_W     = 4;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic accept;   // latch incoming item, issue line store reads
    logic step;     // shift window, write line stores, advance input position
    logic sum;      // form neighbourhood sums
    logic mul;      // reciprocal multiply
    logic load;     // correct quotient, load output register
  } bs3_cmd_t;

  typedef struct packed {
    logic emit;     // current item produces a result
    logic out_free; // output register can take a new result
  } bs3_status_t;

  // floor(2^24 / d) for the neighbour counts
  function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] d);
    logic [RECIP_W-1:0] m;
    case (d)
      4'd1:    m = 25'd16777216;
      4'd2:    m = 25'd8388608;
      4'd3:    m = 25'd5592405;
      4'd4:    m = 25'd4194304;
      4'd5:    m = 25'd3355443;
      4'd6:    m = 25'd2796202;
      4'd7:    m = 25'd2396745;
      4'd8:    m = 25'd2097152;
      4'd9:    m = 25'd1864135;
      default: m = '0;
    endcase
    return m;
  endfunction
endpackage
`default_nettype wire

### rtl/bs3_ctrl.sv
// Sequencing state machine for one item at a time.
`default_nettype none
module bs3_ctrl import bs3_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire bs3_status_t status,
  output bs3_cmd_t         cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIX  = 3'd4;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) state_next = S_READ;
      end
      S_READ: begin
        cmd.step   = 1'b1;
        state_next = status.emit ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_FIX;
      end
      S_FIX: begin
        // hold until the output register is free
        cmd.load = status.out_free;
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### rtl/bs3_datapath.sv
// Line stores, 3x3 window, position counters, mean arithmetic and output register.
`default_nettype none
module bs3_datapath import bs3_pkg::*; #(
  parameter int MAX_SIZE     = 1024,
  parameter int CHANNEL_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bs3_cmd_t          cmd,
  output bs3_status_t            status,
  input  wire logic [DATA_W-1:0] s_tdata,
  input  wire logic              s_tuser,
  input  wire logic              cfg_valid,
  input  wire logic [SIZE_W-1:0] cfg_data,
  input  wire logic              m_tready,
  output logic                   m_tvalid,
  output logic [DATA_W-1:0]      m_tdata,
  output logic                   m_tlast
);
  localparam int DW = $clog2(MAX_SIZE + 1);
  localparam int RW = DW + 1;
  localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int CB = CHANNEL_BITS;
  localparam int PW = 3 * CB;
  localparam int SW = CB + COUNT_W;
  localparam int PRW = SW + RECIP_W;

  logic [SIZE_W-1:0] image_size;
  logic [12:0]       size_w;
  logic [DW-1:0]     dim;
  logic [DW-1:0]     in_col, out_col, c;
  logic [RW-1:0]     in_row, out_row;
  logic [DW:0]       c_inc, oc_inc;
  logic [AW-1:0]     addr;

  logic [PW-1:0] upper_mem [MAX_SIZE];
  logic [PW-1:0] mid_mem   [MAX_SIZE];
  logic [PW-1:0] rd_up, rd_mid, pix;
  logic [PW-1:0] win [3][3];

  logic [SW-1:0]      sum_c [3];
  logic [SW-1:0]      sum_r [3];
  logic [PRW-1:0]     prod  [3];
  logic [COUNT_W-1:0] count_c, count_r;
  logic               last_r;
  logic [2:0]         row_ok, col_ok;
  logic [1:0]         nrows, ncols;
  logic [SW-1:0]      q0 [3];
  logic [SW-1:0]      q  [3];
  logic [SW+COUNT_W-1:0] rem [3];
  logic               is_last;

  // side length clamped to 1..MAX_SIZE
  always_comb begin
    size_w = 13'(image_size);
    if (size_w == 13'd0)                 dim = DW'(1);
    else if (size_w > 13'(MAX_SIZE))     dim = DW'(MAX_SIZE);
    else                                 dim = DW'(size_w);
  end

  assign c      = (in_col >= dim) ? '0 : in_col;
  assign addr   = c[AW-1:0];
  assign c_inc  = {1'b0, c} + 1'b1;
  assign oc_inc = {1'b0, out_col} + 1'b1;

  assign status.emit     = (in_row >= RW'(2)) || (in_row == RW'(1) && c != '0);
  assign status.out_free = !m_tvalid || m_tready;

  // line stores: read on accept, write back on step
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_up  <= upper_mem[addr];
      rd_mid <= mid_mem[addr];
    end
    if (cmd.step) begin
      upper_mem[addr] <= rd_mid;
      mid_mem[addr]   <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (s_tuser == OP_PIXEL && in_row < RW'(dim))
        pix <= {s_tdata[32 +: CB], s_tdata[16 +: CB], s_tdata[0 +: CB]};
      else
        pix <= '0;
    end
    if (cmd.step) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= rd_up;
      win[1][2] <= rd_mid;
      win[2][2] <= pix;
    end
  end

  // neighbourhood sums over the valid part of the window
  always_comb begin
    row_ok  = {(RW+1)'(out_row) + 1'b1 < (RW+1)'(dim), 1'b1, out_row != '0};
    col_ok  = {oc_inc < (DW+1)'(dim), 1'b1, out_col != '0};
    nrows   = 2'(row_ok[0]) + 2'(row_ok[2]) + 2'd1;
    ncols   = 2'(col_ok[0]) + 2'(col_ok[2]) + 2'd1;
    count_c = COUNT_W'(nrows) * COUNT_W'(ncols);
    for (int ch = 0; ch < 3; ch++) begin
      sum_c[ch] = '0;
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++)
          if (row_ok[k] && col_ok[j])
            sum_c[ch] = sum_c[ch] + SW'(win[k][j][ch*CB +: CB]);
    end
  end

  assign is_last = ((RW+1)'(out_row) + 1'b1 >= (RW+1)'(dim)) && (oc_inc >= (DW+1)'(dim));

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sum_r   <= sum_c;
      count_r <= count_c;
      last_r  <= is_last;
    end
    if (cmd.mul)
      for (int ch = 0; ch < 3; ch++)
        prod[ch] <= PRW'(sum_r[ch]) * PRW'(recip(count_r));
  end

  // reciprocal quotient is exact or one short: one compare fixes it
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      q0[ch]  = prod[ch][RECIP_SHIFT +: SW];
      rem[ch] = (SW+COUNT_W)'(sum_r[ch]) - (SW+COUNT_W)'(q0[ch]) * (SW+COUNT_W)'(count_r);
      q[ch]   = (rem[ch] >= (SW+COUNT_W)'(count_r)) ? q0[ch] + 1'b1 : q0[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tdata <= {FIELD_W'(q[2]), FIELD_W'(q[1]), FIELD_W'(q[0])};
      m_tlast <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  // configuration and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= SIZE_RESET;
      in_col <= '0; in_row <= '0; out_col <= '0; out_row <= '0;
    end else if (cfg_valid) begin
      image_size <= cfg_data;
      in_col <= '0; in_row <= '0; out_col <= '0; out_row <= '0;
    end else begin
      if (cmd.step) begin
        if (c_inc >= (DW+1)'(dim)) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
        end else begin
          in_col <= DW'(c_inc);
        end
      end
      if (cmd.load) begin
        if (last_r) begin
          in_col <= '0; in_row <= '0; out_col <= '0; out_row <= '0;
        end else if (oc_inc >= (DW+1)'(dim)) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
        end else begin
          out_col <= DW'(oc_inc);
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/box_smooth_3x3.sv
// Top level of the streaming 3x3 box smoothing filter.
// An input transfer reaches the output register through the read, window step, sum, multiply
// and correct steps; the correct step waits while the output register is full. Items are taken
//   one at a time, and an item with no result ends after the window step.
// Results lag the input by one row plus one pixel; flush items drain the tail.
// Reset (rst, synchronous): counters cleared, image_size back to 1024, output empty;
//   line stores are not cleared.
`default_nettype none
module box_smooth_3x3 import bs3_pkg::*; #(
  parameter int MAX_SIZE     = 1024,
  parameter int CHANNEL_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // input stream
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [DATA_W-1:0] s_tdata,   // red[15:0], green[31:16], blue[47:32]
  input  wire logic              s_tuser,   // operation: pixel or flush
  // image_size register
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [SIZE_W-1:0] cfg_data,
  // result stream
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [DATA_W-1:0]      m_tdata,   // red_out[15:0], green_out[31:16], blue_out[47:32]
  output logic                   m_tlast    // frame_last
);
  bs3_cmd_t    cmd;
  bs3_status_t status;

  // writes must arrive only while idle (the block does not enforce this); the register port never stalls
  assign cfg_ready = 1'b1;

  bs3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bs3_datapath #(
    .MAX_SIZE     (MAX_SIZE),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );
endmodule
`default_nettype wire

### rtl/bs3_checker.sv
// Port-level checks for the box smoothing block, bound to the top level.
`default_nettype none
module bs3_checker import bs3_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_tvalid,
  input wire logic              s_tready,
  input wire logic              m_tvalid,
  input wire logic              m_tready,
  input wire logic [DATA_W-1:0] m_tdata,
  input wire logic              m_tlast
);
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transfer taken while busy");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && s_tvalid && s_tready |=> !m_tvalid)
    else $error("result appeared too early");
endmodule

bind box_smooth_3x3 bs3_checker u_bs3_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire
